[rtl/bfp_pkg.sv]
// Shared types and constants of the bit-field packer and unpacker.
// Holds operation codes, status codes, the command and result records.
// No dependencies.
package bfp_pkg;

    localparam logic [2:0] OP_UNPACK = 3'd0;
    localparam logic [2:0] OP_PACK   = 3'd1;
    localparam logic [2:0] OP_REWIND = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_OVR_CUR = 2'd1;
    localparam logic [1:0] STAT_OVR_NXT = 2'd2;

    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    typedef struct packed {
        logic [2:0]  op;
        logic [6:0]  nbits;
        logic        rev;
        logic [63:0] value;
        logic [5:0]  addr;
        logic [6:0]  wpos;
        logic [5:0]  bpos;
        logic        pos_ok;
        logic        nxt_in;
        logic [6:0]  n;
        logic [1:0]  status;
        logic [6:0]  wpos_new;
        logic [5:0]  bpos_new;
    } cmd_t;

    typedef struct packed {
        logic [63:0] data;
        logic [1:0]  status;
        logic [6:0]  word_pos;
        logic [5:0]  bit_pos;
    } res_t;

endpackage

[rtl/bfp_fifo.sv]
// Small register-based first-in first-out queue of generic width.
// Used between front and back and at the result side. No dependencies.
module bfp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [W-1:0]                 din,
    input  logic                         rd_en,
    output logic [W-1:0]                 dout,
    output logic                         full,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;
    assign dout  = mem_reg[rptr_reg];
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH-1)) ? '0 : wptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH-1)) ? '0 : rptr_reg + PW'(1);
        end
        cnt_next = cnt_reg + CW'(do_wr) - CW'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

[rtl/bfp_front.sv]
// Front end: holds the words-in-use register and the running positions,
// classifies each item and emits a command. Depends on bfp_pkg.
module bfp_front #(
    parameter int DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [6:0]        cfg_data,
    input  logic              push,
    input  logic [2:0]        operation,
    input  logic [6:0]        field_bits,
    input  logic              reversed,
    input  logic [63:0]       value,
    input  logic [5:0]        word_addr,
    input  logic              cmd_full,
    output logic              cmd_push,
    output bfp_pkg::cmd_t     cmd
);
    logic [6:0] num_words_reg;
    logic [6:0] wpos_reg, wpos_next;
    logic [5:0] bpos_reg, bpos_next;
    logic [7:0] n8;
    logic [6:0] nb;
    logic [6:0] b;
    logic       pos_ok, nxt_in, advance;
    logic [1:0] status;

    always_comb
    begin
        if (num_words_reg == '0)
        begin
            n8 = 8'd1;
        end
        else if ({1'b0, num_words_reg} > 8'(DEPTH))
        begin
            n8 = 8'(DEPTH);
        end
        else
        begin
            n8 = {1'b0, num_words_reg};
        end

        if (field_bits == '0)
        begin
            nb = 7'd1;
        end
        else if (field_bits > 7'd64)
        begin
            nb = 7'd64;
        end
        else
        begin
            nb = field_bits;
        end

        pos_ok  = ({1'b0, wpos_reg} < n8);
        nxt_in  = (({1'b0, wpos_reg} + 8'd1) < n8);
        b       = {1'b0, bpos_reg} + nb;
        advance = 1'b0;
        status  = bfp_pkg::STAT_OK;
        wpos_next = wpos_reg;
        bpos_next = bpos_reg;

        case (operation)
            bfp_pkg::OP_UNPACK:
            begin
                if (!pos_ok)
                begin
                    status = bfp_pkg::STAT_OVR_CUR;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            bfp_pkg::OP_PACK:
            begin
                if (!pos_ok)
                begin
                    status = bfp_pkg::STAT_OVR_CUR;
                end
                else if (!nxt_in && (b > 7'd64))
                begin
                    status = bfp_pkg::STAT_OVR_NXT;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            bfp_pkg::OP_REWIND:
            begin
                wpos_next = '0;
                bpos_next = '0;
            end
            default:
            begin
                advance = 1'b0;
            end
        endcase

        if (advance)
        begin
            wpos_next = wpos_reg + 7'(b[6]);
            bpos_next = b[5:0];
        end

        cmd_push      = push && !cmd_full;
        cmd.op        = operation;
        cmd.nbits     = nb;
        cmd.rev       = reversed;
        cmd.value     = value;
        cmd.addr      = word_addr;
        cmd.wpos      = wpos_reg;
        cmd.bpos      = bpos_reg;
        cmd.pos_ok    = pos_ok;
        cmd.nxt_in    = nxt_in;
        cmd.n         = n8[6:0];
        cmd.status    = status;
        cmd.wpos_new  = wpos_next;
        cmd.bpos_new  = bpos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_words_reg <= 7'd64;
            wpos_reg      <= '0;
            bpos_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                num_words_reg <= cfg_data;
            end
            if (cmd_push)
            begin
                wpos_reg <= wpos_next;
                bpos_reg <= bpos_next;
            end
        end
    end

endmodule

[rtl/bfp_back.sv]
// Back end: even and odd word banks, a read stage and an execute stage that
// shifts, masks, mirrors and writes back. Depends on bfp_pkg.
module bfp_back #(
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cmd_empty,
    input  bfp_pkg::cmd_t                              cmd,
    output logic                                       cmd_pop,
    input  logic [$clog2(bfp_pkg::OUT_DEPTH+1)-1:0]    out_count,
    output logic                                       res_push,
    output bfp_pkg::res_t                              res
);
    localparam int BANK = (DEPTH + 1) / 2;
    localparam int BAW  = (BANK > 1) ? $clog2(BANK) : 1;
    localparam int BN   = 2 ** BAW;
    localparam int OCW  = $clog2(bfp_pkg::OUT_DEPTH + 1) + 1;

    logic [63:0]    bank_e [BN];
    logic [63:0]    bank_o [BN];
    logic [BN-1:0]  vld_e_reg, vld_o_reg;

    logic [7:0]     w, e_w;
    logic [BAW-1:0] e_idx, o_idx;

    logic           ex_valid_reg;
    bfp_pkg::cmd_t  ex_reg;
    logic [BAW-1:0] ex_eidx_reg, ex_oidx_reg;
    logic [63:0]    e_rd_reg, o_rd_reg;
    logic           e_vld_reg, o_vld_reg;

    logic           lw_e_en_reg, lw_o_en_reg;
    logic [BAW-1:0] lw_e_idx_reg, lw_o_idx_reg;
    logic [63:0]    lw_e_data_reg, lw_o_data_reg;
    logic           clr_reg;
    logic [6:0]     clr_n_reg;

    logic [63:0]    e_old, o_old, cur, nxt, src, f, word_old;
    logic           we_e, we_o, addr_ok, is_rewind;
    logic [63:0]    wd_e, wd_o, data;

    function automatic logic [63:0] shape(input logic [63:0] s, input logic [6:0] nb,
                                          input logic rv);
        logic [5:0]  drop;
        logic [63:0] m;
        drop = 6'(7'd64 - nb);
        for (int i = 0; i < 64; i++)
        begin
            m[i] = s[63-i];
        end
        if (rv)
        begin
            return m >> drop;
        end
        return (s << drop) >> drop;
    endfunction

    // Credit check: the item in the execute stage also claims a result queue slot.
    assign cmd_pop = !cmd_empty &&
                     ((OCW'(out_count) + OCW'(ex_valid_reg)) <= OCW'(bfp_pkg::OUT_DEPTH - 1));

    always_comb
    begin
        if ((cmd.op == bfp_pkg::OP_WRITE) || (cmd.op == bfp_pkg::OP_READ))
        begin
            w = {2'b0, cmd.addr};
        end
        else
        begin
            w = {1'b0, cmd.wpos};
        end
        e_w   = w[0] ? (w + 8'd1) : w;
        e_idx = BAW'(e_w >> 1);
        o_idx = BAW'(w >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            ex_reg      <= cmd;
            ex_eidx_reg <= e_idx;
            ex_oidx_reg <= o_idx;
            e_rd_reg    <= bank_e[e_idx];
            o_rd_reg    <= bank_o[o_idx];
            e_vld_reg   <= vld_e_reg[e_idx];
            o_vld_reg   <= vld_o_reg[o_idx];
        end
        if (ex_valid_reg && we_e)
        begin
            bank_e[ex_eidx_reg] <= wd_e;
        end
        if (ex_valid_reg && we_o)
        begin
            bank_o[ex_oidx_reg] <= wd_o;
        end
        lw_e_idx_reg  <= ex_eidx_reg;
        lw_o_idx_reg  <= ex_oidx_reg;
        lw_e_data_reg <= wd_e;
        lw_o_data_reg <= wd_o;
        clr_n_reg     <= ex_reg.n;
    end

    // Forwarding covers the write or clear made at the same edge as this read.
    always_comb
    begin
        if (lw_e_en_reg && (lw_e_idx_reg == ex_eidx_reg))
        begin
            e_old = lw_e_data_reg;
        end
        else if (clr_reg && (8'({ex_eidx_reg, 1'b0}) < {1'b0, clr_n_reg}))
        begin
            e_old = '0;
        end
        else
        begin
            e_old = e_vld_reg ? e_rd_reg : '0;
        end

        if (lw_o_en_reg && (lw_o_idx_reg == ex_oidx_reg))
        begin
            o_old = lw_o_data_reg;
        end
        else if (clr_reg && (8'({ex_oidx_reg, 1'b1}) < {1'b0, clr_n_reg}))
        begin
            o_old = '0;
        end
        else
        begin
            o_old = o_vld_reg ? o_rd_reg : '0;
        end

        cur      = ex_reg.wpos[0] ? o_old : e_old;
        nxt      = ex_reg.wpos[0] ? e_old : o_old;
        word_old = ex_reg.addr[0] ? o_old : e_old;
        addr_ok  = ({2'b0, ex_reg.addr} < 8'(DEPTH));
        is_rewind = (ex_reg.op == bfp_pkg::OP_REWIND);

        src = cur >> ex_reg.bpos;
        if ((ex_reg.bpos != '0) && ex_reg.nxt_in)
        begin
            src = src | ((nxt << 1) << (~ex_reg.bpos));
        end
        f = shape(ex_reg.value, ex_reg.nbits, ex_reg.rev);

        we_e = 1'b0;
        we_o = 1'b0;
        wd_e = '0;
        wd_o = '0;
        data = '0;

        case (ex_reg.op)
            bfp_pkg::OP_UNPACK:
            begin
                if (ex_reg.pos_ok)
                begin
                    data = shape(src, ex_reg.nbits, ex_reg.rev);
                end
            end
            bfp_pkg::OP_PACK:
            begin
                if (ex_reg.pos_ok)
                begin
                    if (ex_reg.wpos[0])
                    begin
                        we_o = 1'b1;
                        wd_o = cur | (f << ex_reg.bpos);
                        we_e = ex_reg.nxt_in && (ex_reg.bpos != '0);
                        wd_e = nxt | ((f >> 1) >> (~ex_reg.bpos));
                    end
                    else
                    begin
                        we_e = 1'b1;
                        wd_e = cur | (f << ex_reg.bpos);
                        we_o = ex_reg.nxt_in && (ex_reg.bpos != '0);
                        wd_o = nxt | ((f >> 1) >> (~ex_reg.bpos));
                    end
                end
            end
            bfp_pkg::OP_WRITE:
            begin
                we_e = addr_ok && !ex_reg.addr[0];
                we_o = addr_ok && ex_reg.addr[0];
                wd_e = ex_reg.value;
                wd_o = ex_reg.value;
            end
            bfp_pkg::OP_READ:
            begin
                if (addr_ok)
                begin
                    data = word_old;
                end
            end
            default:
            begin
                data = '0;
            end
        endcase

        res_push     = ex_valid_reg;
        res.data     = data;
        res.status   = ex_reg.status;
        res.word_pos = ex_reg.wpos_new;
        res.bit_pos  = ex_reg.bpos_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
            vld_e_reg    <= '0;
            vld_o_reg    <= '0;
            lw_e_en_reg  <= 1'b0;
            lw_o_en_reg  <= 1'b0;
            clr_reg      <= 1'b0;
        end
        else
        begin
            ex_valid_reg <= cmd_pop;
            lw_e_en_reg  <= ex_valid_reg && we_e;
            lw_o_en_reg  <= ex_valid_reg && we_o;
            clr_reg      <= ex_valid_reg && is_rewind;
            if (ex_valid_reg && we_e)
            begin
                vld_e_reg[ex_eidx_reg] <= 1'b1;
            end
            if (ex_valid_reg && we_o)
            begin
                vld_o_reg[ex_oidx_reg] <= 1'b1;
            end
            if (ex_valid_reg && is_rewind)
            begin
                for (int i = 0; i < BN; i++)
                begin
                    if (8'(2 * i) < {1'b0, ex_reg.n})
                    begin
                        vld_e_reg[i] <= 1'b0;
                    end
                    if (8'(2 * i + 1) < {1'b0, ex_reg.n})
                    begin
                        vld_o_reg[i] <= 1'b0;
                    end
                end
            end
        end
    end

endmodule

[rtl/bit_field_pack_unpack_top.sv]
// Bit-field packer and unpacker: one item in per cycle while full is low, one result
// item out per item. A result item passes from the command queue through the
// execute stage into the result queue, which drives the result ports.
// Throughput: one item per cycle while the receiver keeps popping, set by the
// execute stage and one read and one write port on each of the two word banks.
// Reset: positions go to zero, words in use to 64, every word reads as zero at once.
module bit_field_pack_unpack_top #(
    parameter int WORDS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  operation,
    input  logic [6:0]  field_bits,
    input  logic        reversed,
    input  logic [63:0] value,
    input  logic [5:0]  word_addr,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] data,
    output logic [1:0]  status,
    output logic [6:0]  word_pos,
    output logic [5:0]  bit_pos
);
    // Positions and word counts never reach beyond 127 words, so no more
    // storage than that is ever addressed.
    localparam int DEPTH = (WORDS < 128) ? WORDS : 128;

    // The front classifies each item and tracks the positions on its own, so
    // the position of the next item never waits on memory. Commands go through
    // a short queue to the back, which reads both banks, forwards the word
    // written by the item just before it, and writes back the merged words.
    bfp_pkg::cmd_t cmd_in, cmd_out;
    bfp_pkg::res_t res_in, res_out;
    logic          cmd_push, cmd_pop, cmd_empty, res_push;
    logic [$clog2(bfp_pkg::CMD_DEPTH+1)-1:0] cmd_count;
    logic [$clog2(bfp_pkg::OUT_DEPTH+1)-1:0] out_count;
    logic          out_full;

    // Configuration is taken in any cycle.
    assign cfg_ready = 1'b1;

    bfp_front #(.DEPTH(DEPTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .push       (push),
        .operation  (operation),
        .field_bits (field_bits),
        .reversed   (reversed),
        .value      (value),
        .word_addr  (word_addr),
        .cmd_full   (full),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in)
    );

    bfp_fifo #(.W($bits(bfp_pkg::cmd_t)), .DEPTH(bfp_pkg::CMD_DEPTH)) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cmd_push),
        .din   (cmd_in),
        .rd_en (cmd_pop),
        .dout  (cmd_out),
        .full  (full),
        .empty (cmd_empty),
        .count (cmd_count)
    );

    bfp_back #(.DEPTH(DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .out_count (out_count),
        .res_push  (res_push),
        .res       (res_in)
    );

    // The back only pops a command when the result queue has room for it,
    // so out_full is never hit by a push.
    bfp_fifo #(.W($bits(bfp_pkg::res_t)), .DEPTH(bfp_pkg::OUT_DEPTH)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (res_push),
        .din   (res_in),
        .rd_en (pop),
        .dout  (res_out),
        .full  (out_full),
        .empty (empty),
        .count (out_count)
    );

    assign data     = res_out.data;
    assign status   = res_out.status;
    assign word_pos = res_out.word_pos;
    assign bit_pos  = res_out.bit_pos;

endmodule

[rtl/bfp_checker.sv]
// Port-level checks for the bit-field packer and unpacker, bound to the top level.
// Depends on bfp_pkg and bit_field_pack_unpack_top.
module bfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [6:0]  cfg_data,
    input logic        push,
    input logic        full,
    input logic [2:0]  operation,
    input logic [6:0]  field_bits,
    input logic        reversed,
    input logic [63:0] value,
    input logic [5:0]  word_addr,
    input logic        empty,
    input logic        pop,
    input logic [63:0] data,
    input logic [1:0]  status,
    input logic [6:0]  word_pos,
    input logic [5:0]  bit_pos
);
    // Status has only three meanings.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status != 2'd3))
        else $error("undefined status code on result");

    // An overrun never carries data.
    a_overrun_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status != bfp_pkg::STAT_OK)) |-> (data == '0))
        else $error("overrun result carries data");

    // Configuration is never back-pressured.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

    // Nothing is waiting on the result side right after reset.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result present right after reset");

endmodule

bind bit_field_pack_unpack_top bfp_checker u_bfp_checker (.*);

[verif/tb.sv]
// Self-checking testbench for the bit-field packer and unpacker.
// A scoreboard class predicts every result item from the inputs that the block accepts.
// Depends on bfp_pkg and bit_field_pack_unpack_top.
module tb;

    // Operation codes 5 to 7 have no function; the block must answer them with zeros.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int STORE_WORDS = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 160;
    localparam int HOLD_PHASE  = 4;

    // The scoreboard holds its own copy of the word store, both positions and the
    // words-in-use register. Each accepted item is run through that copy, and the
    // expected result item is queued until the block delivers its own.
    class pack_scoreboard;
        logic [63:0] words[STORE_WORDS];
        int word_at;
        int bit_at;
        logic [6:0] words_reg;
        bfp_pkg::res_t expected[$];
        int errors;

        function new();
            foreach (words[i]) words[i] = '0;
            word_at = 0;
            bit_at = 0;
            words_reg = 7'd64;
            errors = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void set_words(logic [6:0] v);
            words_reg = v;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function logic [63:0] mirror(logic [63:0] x);
            logic [63:0] r;
            for (int i = 0; i < 64; i++) r[i] = x[63 - i];
            return r;
        endfunction

        // Right-justified field of nb bits, either the low bits or the mirrored top bits.
        function logic [63:0] shape(logic [63:0] src, int nb, logic rv);
            int drop;
            drop = 64 - nb;
            if (rv) return mirror(src) >> drop;
            return (src << drop) >> drop;
        endfunction

        function void note_item(logic [2:0] op, logic [6:0] fb, logic rv,
                                logic [63:0] val, logic [5:0] ad);
            int n;
            int nb;
            int b;
            bit adv;
            logic [63:0] src;
            logic [63:0] nxt;
            logic [63:0] f;
            bfp_pkg::res_t r;

            // Out-of-range settings clamp rather than fault.
            n = (words_reg == 0) ? 1 : (words_reg > STORE_WORDS ? STORE_WORDS : words_reg);
            nb = (fb == 0) ? 1 : (fb > 64 ? 64 : fb);
            r.data = '0;
            r.status = bfp_pkg::STAT_OK;
            adv = 0;
            case (op)
                bfp_pkg::OP_UNPACK: begin
                    if (word_at >= n) r.status = bfp_pkg::STAT_OVR_CUR;
                    else begin
                        // Bits beyond the last word in use read as zero.
                        nxt = (word_at + 1 < n) ? words[word_at + 1] : '0;
                        src = words[word_at] >> bit_at;
                        if (bit_at != 0) src |= nxt << (64 - bit_at);
                        r.data = shape(src, nb, rv);
                        adv = 1;
                    end
                end
                bfp_pkg::OP_PACK: begin
                    if (word_at >= n) r.status = bfp_pkg::STAT_OVR_CUR;
                    else begin
                        f = shape(val, nb, rv);
                        words[word_at] |= f << bit_at;
                        if (word_at + 1 < n) begin
                            if (bit_at != 0) words[word_at + 1] |= f >> (64 - bit_at);
                            adv = 1;
                        end else if (bit_at + nb > 64) begin
                            // The spilled part is dropped and the position holds.
                            r.status = bfp_pkg::STAT_OVR_NXT;
                        end else adv = 1;
                    end
                end
                bfp_pkg::OP_REWIND: begin
                    word_at = 0;
                    bit_at = 0;
                    for (int i = 0; i < n; i++) words[i] = '0;
                end
                bfp_pkg::OP_WRITE: words[ad] = val;
                bfp_pkg::OP_READ: r.data = words[ad];
                default: ;
            endcase
            if (adv) begin
                b = bit_at + nb;
                word_at = (word_at + (b >> 6)) & 'h7f;
                bit_at = b & 'h3f;
            end
            r.word_pos = word_at[6:0];
            r.bit_pos = bit_at[5:0];
            expected.push_back(r);
        endfunction

        task check_result(logic [63:0] d, logic [1:0] st, logic [6:0] wp, logic [5:0] bp);
            bfp_pkg::res_t e;
            if (expected.size() == 0) begin
                report("result item arrived with nothing expected");
                return;
            end
            e = expected.pop_front();
            if (d !== e.data)
                report($sformatf("data %h, expected %h", d, e.data));
            if (st !== e.status)
                report($sformatf("status %0d, expected %0d", st, e.status));
            if (wp !== e.word_pos)
                report($sformatf("word_pos %0d, expected %0d", wp, e.word_pos));
            if (bp !== e.bit_pos)
                report($sformatf("bit_pos %0d, expected %0d", bp, e.bit_pos));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;
    logic        push;
    logic        full;
    logic [2:0]  operation;
    logic [6:0]  field_bits;
    logic        reversed;
    logic [63:0] value;
    logic [5:0]  word_addr;
    logic        empty;
    logic        pop;
    logic [63:0] data;
    logic [1:0]  status;
    logic [6:0]  word_pos;
    logic [5:0]  bit_pos;

    pack_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    bit hold_done;
    int phase_idx = -1;
    int cycles = 0;

    bit_field_pack_unpack_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .field_bits (field_bits),
        .reversed   (reversed),
        .value      (value),
        .word_addr  (word_addr),
        .empty      (empty),
        .pop        (pop),
        .data       (data),
        .status     (status),
        .word_pos   (word_pos),
        .bit_pos    (bit_pos)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit. It sits far above the slowest legal run, including the long hold-off.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver side. Pop is decided at the falling edge; a long hold-off overrides the
    // random stalling so that the block fills up and has to push back on its input.
    initial
    begin
        pop = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && (phase_idx == HOLD_PHASE)) begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                pop = 1'b0;
                hold_left--;
            end else
                pop = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(data, status, word_pos, bit_pos);
    end

    // Offers one item, with random idle cycles first, and holds it until it is taken.
    // Called and returning at a falling edge.
    task send_item(logic [2:0] op, logic [6:0] fb, logic rv, logic [63:0] val,
                   logic [5:0] ad);
        while ($urandom_range(99) < send_idle_pct) begin
            push = 1'b0;
            @(negedge clk);
        end
        operation = op;
        field_bits = fb;
        reversed = rv;
        value = val;
        word_addr = ad;
        push = 1'b1;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_item(op, fb, rv, val, ad);
        @(negedge clk);
    endtask

    // Waits until every expected result item has come, then idles for a margin.
    task drain();
        push = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task write_words_reg(logic [6:0] v);
        cfg_data = v;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_words(v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly legal widths, sometimes zero or above 64 to reach the clamping.
    function logic [6:0] rand_bits();
        if ($urandom_range(9) == 0) return 7'($urandom_range(127, 0));
        return 7'($urandom_range(64, 1));
    endfunction

    function logic [2:0] rand_op();
        int r;
        r = $urandom_range(99);
        if (r < 35) return bfp_pkg::OP_PACK;
        if (r < 65) return bfp_pkg::OP_UNPACK;
        if (r < 69) return bfp_pkg::OP_REWIND;
        if (r < 80) return bfp_pkg::OP_WRITE;
        if (r < 95) return bfp_pkg::OP_READ;
        return 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    endfunction

    // One burst of random items. Most bursts are well-formed: packs, sometimes after a
    // rewind, read back by word, or words written and then unpacked as fields. The rest
    // is noise over every operation. Returns the number of items sent.
    task send_burst(output int sent);
        int kind;
        int k;
        kind = $urandom_range(9);
        k = $urandom_range(12, 2);
        sent = 0;
        if (kind < 4) begin
            if ($urandom_range(1)) begin
                send_item(bfp_pkg::OP_REWIND, rand_bits(), 1'($urandom_range(1)),
                          rand_word(), 6'd0);
                sent++;
            end
            repeat (k) begin
                send_item(bfp_pkg::OP_PACK, rand_bits(), 1'($urandom_range(1)),
                          rand_word(), 6'd0);
                sent++;
            end
            for (int i = 0; i < 3; i++) begin
                send_item(bfp_pkg::OP_READ, rand_bits(), 1'($urandom_range(1)),
                          rand_word(), 6'(i));
                sent++;
            end
        end else if (kind < 7) begin
            send_item(bfp_pkg::OP_REWIND, rand_bits(), 1'($urandom_range(1)),
                      rand_word(), 6'd0);
            sent++;
            for (int i = 0; i < 4; i++) begin
                send_item(bfp_pkg::OP_WRITE, rand_bits(), 1'($urandom_range(1)),
                          rand_word(), 6'(i));
                sent++;
            end
            repeat (k) begin
                send_item(bfp_pkg::OP_UNPACK, rand_bits(), 1'($urandom_range(1)),
                          rand_word(), 6'd0);
                sent++;
            end
        end else begin
            repeat (k) begin
                send_item(rand_op(), rand_bits(), 1'($urandom_range(1)), rand_word(),
                          6'($urandom_range(63)));
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [6:0] words_list[8];
        int phase_count;
        int n;
        bit paused;

        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        push = 1'b0;
        operation = bfp_pkg::OP_UNPACK;
        field_bits = '0;
        reversed = 1'b0;
        value = '0;
        word_addr = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, starting from the reset state with all 64 words in use.
        send_item(bfp_pkg::OP_READ, 7'd1, 1'b0, '0, 6'd0);
        send_item(bfp_pkg::OP_WRITE, 7'd1, 1'b0, '1, 6'd0);
        send_item(bfp_pkg::OP_WRITE, 7'd64, 1'b1, 64'hF0F0_CCCC_AAAA_5555, 6'd63);
        send_item(bfp_pkg::OP_READ, 7'd1, 1'b0, '0, 6'd63);
        send_item(bfp_pkg::OP_UNPACK, 7'd0, 1'b0, '0, 6'd0);
        send_item(bfp_pkg::OP_UNPACK, 7'd64, 1'b0, '0, 6'd0);
        send_item(bfp_pkg::OP_UNPACK, 7'd127, 1'b1, '0, 6'd0);
        send_item(bfp_pkg::OP_UNPACK, 7'd13, 1'b1, '0, 6'd0);
        send_item(bfp_pkg::OP_PACK, 7'd64, 1'b0, '1, 6'd0);
        send_item(bfp_pkg::OP_PACK, 7'd7, 1'b1, 64'h0F, 6'd0);
        send_item(OP_SPARE_FIRST, 7'd64, 1'b1, '1, 6'd63);
        send_item(OP_SPARE_FIRST + 3'd1, 7'd1, 1'b0, '1, 6'd1);
        send_item(OP_SPARE_LAST, 7'd127, 1'b1, '1, 6'd0);
        send_item(bfp_pkg::OP_REWIND, 7'd1, 1'b0, '0, 6'd0);
        send_item(bfp_pkg::OP_READ, 7'd1, 1'b0, '0, 6'd63);
        drain();

        // With one word in use: a spill past the last word, then overruns at the end.
        write_words_reg(7'd1);
        send_item(bfp_pkg::OP_PACK, 7'd40, 1'b0, '1, 6'd0);
        send_item(bfp_pkg::OP_PACK, 7'd40, 1'b1, 64'hAAAA_AAAA_3333_3333, 6'd0);
        send_item(bfp_pkg::OP_READ, 7'd1, 1'b0, '0, 6'd0);
        send_item(bfp_pkg::OP_UNPACK, 7'd30, 1'b0, '0, 6'd0);
        send_item(bfp_pkg::OP_UNPACK, 7'd5, 1'b0, '0, 6'd0);
        send_item(bfp_pkg::OP_PACK, 7'd5, 1'b0, '1, 6'd0);
        send_item(bfp_pkg::OP_REWIND, 7'd1, 1'b0, '0, 6'd0);
        drain();

        // Random part: phases across register settings, extremes included, and across
        // the idling patterns.
        words_list = '{7'd64, 7'd0, 7'd127, 7'd3, 7'd1, 7'd100, 7'd64, 7'd2};
        for (int p = 0; p < 8; p++) begin
            write_words_reg(words_list[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            // The receiver starts its long hold-off when this reaches the hold phase,
            // while the sender keeps offering items.
            phase_idx = p;
            phase_count = 0;
            paused = 0;
            while (phase_count < PHASE_ITEMS) begin
                send_burst(n);
                phase_count += n;
                // Sender pause until the block has delivered everything.
                if (p == 1 && !paused && phase_count > PHASE_ITEMS / 2) begin
                    paused = 1;
                    drain();
                end
            end
            drain();
        end

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
